@@ design/radix_digit_converter_top_defines.svh @@
// ----------------------------------------------------------------------------
// radix_digit_converter_top_defines.svh
// Assertion macros shared by the converter's checking code.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_TOP_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_TOP_DEFINES_SVH

// condition must hold at every edge out of reset
`define RDC_ASSERT_ALWAYS(label, clk_sig, rst_sig, cond, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RDC_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |-> (cons)) else $error(msg);

`endif

@@ design/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdc_pkg
// Types, constants and helpers shared by the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

    // fixed field widths
    localparam int WORD_W  = 64;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam int COUNT_W = 7;

    // radix limits and reset value
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;

    // ASCII mapping
    localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0]  ASCII_ALPHA = 7'd55;  // 'A' minus ten

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // one queued conversion request
    typedef struct packed {
        logic [WORD_W-1:0]  value;
        logic [RADIX_W-1:0] base;
    } rdc_item_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } rdc_state_t;

    // clamp a raw radix register into 2..36
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] b;
        b = r;
        if (r < RADIX_MIN)
            b = RADIX_MIN;
        else if (r > RADIX_MAX)
            b = RADIX_MAX;
        return b;
    endfunction

    // digit value to ASCII character
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN)
            c = CHAR_W'(d) + ASCII_ZERO;
        else
            c = CHAR_W'(d) + ASCII_ALPHA;
        return c;
    endfunction

endpackage

@@ design/rdc_front.sv @@
// ----------------------------------------------------------------------------
// rdc_front
// Holds the radix register, accepts items, masks the value, clamps the base
// and queues each request for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module rdc_front #(
    parameter int VALUE_BITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rdc_pkg::RADIX_W-1:0] cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [rdc_pkg::WORD_W-1:0]  value,
    output logic                        item_valid,
    output rdc_pkg::rdc_item_t          item,
    input  logic                        item_take
);
    import rdc_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    rdc_item_t          queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic               push_ok;
    logic               take_ok;
    rdc_item_t          new_item;

    assign cfg_ready = 1'b1;

    // radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (cfg_valid)
            radix_reg <= cfg_data;
    end

    // classify: drop unused value bits, clamp the base
    always_comb
    begin
        new_item.value = WORD_W'(value[VALUE_BITS-1:0]);
        new_item.base  = clamp_radix(radix_reg);
    end

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign item_valid = (cnt_reg != '0);
    assign item       = queue_reg[rd_ptr_reg];
    assign push_ok    = push && !full;
    assign take_ok    = item_take && item_valid;

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push_ok)
            queue_reg[wr_ptr_reg] <= new_item;
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push_ok)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (take_ok)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push_ok && !take_ok)
                cnt_reg <= cnt_reg + 1'b1;
            else if (take_ok && !push_ok)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

@@ design/rdc_divider.sv @@
// ----------------------------------------------------------------------------
// rdc_divider
// Restoring divider, one quotient bit per cycle, small divisor (2 to 36).
// ----------------------------------------------------------------------------
module rdc_divider #(
    parameter int VALUE_BITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [VALUE_BITS-1:0]       dividend,
    input  logic [rdc_pkg::RADIX_W-1:0] divisor,
    output logic                        done,
    output logic [VALUE_BITS-1:0]       quotient,
    output logic [rdc_pkg::RADIX_W-1:0] remainder
);
    import rdc_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] quo_reg;
    logic [RADIX_W-1:0]    rem_reg;
    logic [RADIX_W-1:0]    div_reg;
    logic [CNT_W-1:0]      bit_cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [RADIX_W:0]      trial;
    logic                  fits;

    // one shift-subtract step
    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[VALUE_BITS-2:0], fits};
            rem_reg <= fits ? RADIX_W'(trial - {1'b0, div_reg}) : trial[RADIX_W-1:0];
        end
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg    <= 1'b1;
                bit_cnt_reg <= CNT_W'(VALUE_BITS - 1);
            end
            else if (busy_reg)
            begin
                if (bit_cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    bit_cnt_reg <= bit_cnt_reg - 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ design/rdc_back.sv @@
// ----------------------------------------------------------------------------
// rdc_back
// Takes queued requests, produces remainders on its own divider into a
// digit memory, then reads them back most significant first into the
// result register.
// ----------------------------------------------------------------------------
module rdc_back #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  rdc_pkg::rdc_item_t          item,
    output logic                        item_take,
    input  logic                        pop,
    output logic                        empty,
    output logic [rdc_pkg::CHAR_W-1:0]  digit_char,
    output logic [rdc_pkg::COUNT_W-1:0] digit_total,
    output logic                        last_digit
);
    import rdc_pkg::*;

    localparam int                 IDX_W   = $clog2(MAX_DIGITS);
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DIGITS);

    rdc_state_t            state_reg;
    rdc_state_t            state_next;
    logic [RADIX_W-1:0]    base_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    emit_reg;
    logic [RADIX_W-1:0]    digit_mem [MAX_DIGITS];
    logic [RADIX_W-1:0]    rd_data_reg;
    logic                  rd_pend_reg;
    logic                  pend_last_reg;
    logic [COUNT_W-1:0]    pend_total_reg;
    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     out_char_reg;
    logic [COUNT_W-1:0]    out_total_reg;
    logic                  out_last_reg;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [RADIX_W-1:0]    div_divisor;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quo;
    logic [RADIX_W-1:0]    div_rem;

    logic                  pop_ok;
    logic                  out_free;
    logic                  conv_end;
    logic                  mem_we;
    logic                  rd_en;
    logic                  emit_last;
    logic [COUNT_W-1:0]    rd_pos;

    rdc_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // common conditions
    assign pop_ok    = pop && out_valid_reg;
    assign out_free  = !rd_pend_reg && (!out_valid_reg || pop_ok);
    assign conv_end  = (div_quo == '0) || (count_reg + 1'b1 == MAX_CNT);
    assign emit_last = (emit_reg + 1'b1 == count_reg);
    assign rd_pos    = count_reg - 1'b1 - emit_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done && conv_end)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free && emit_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        item_take    = 1'b0;
        div_start    = 1'b0;
        div_dividend = div_quo;
        div_divisor  = base_reg;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_take    = item_valid;
                div_start    = item_valid;
                div_dividend = item.value[VALUE_BITS-1:0];
                // base_reg loads on this same edge, so the first step takes it directly
                div_divisor  = item.base;
            end
            ST_DIVIDE:
            begin
                mem_we    = div_done;
                div_start = div_done && !conv_end;
            end
            ST_EMIT:
                rd_en = out_free;
            default:
            begin
                item_take = 1'b0;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (item_take)
                count_reg <= '0;
            else if (mem_we)
                count_reg <= count_reg + 1'b1;
            if (mem_we)
                emit_reg <= '0;
            else if (rd_en)
                emit_reg <= emit_reg + 1'b1;
        end
    end

    // base for the running conversion
    always_ff @(posedge clk)
    begin
        if (item_take)
            base_reg <= item.base;
    end

    // digit memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[count_reg[IDX_W-1:0]] <= div_rem;
        if (rd_en)
        begin
            rd_data_reg    <= digit_mem[rd_pos[IDX_W-1:0]];
            pend_last_reg  <= emit_last;
            pend_total_reg <= count_reg;
        end
    end

    // read in flight and result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= rd_en;
            if (rd_pend_reg)
                out_valid_reg <= 1'b1;
            else if (pop_ok)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            out_char_reg  <= digit_to_ascii(rd_data_reg);
            out_total_reg <= pend_total_reg;
            out_last_reg  <= pend_last_reg;
        end
    end

    assign empty       = !out_valid_reg;
    assign digit_char  = out_char_reg;
    assign digit_total = out_total_reg;
    assign last_digit  = out_last_reg;

endmodule

@@ design/radix_digit_converter_top.sv @@
// ----------------------------------------------------------------------------
// radix_digit_converter_top: unsigned value to radix digit string
// Per value: one division per digit on the one bit-serial divider; the first
// digit is read out only after the last division. Readout fetches a digit only
// once the previous one is in the result register; the next value divides only
// after all digits are read from memory. Async active-low reset: queues empty, radix = 16.
// ----------------------------------------------------------------------------
`include "radix_digit_converter_top_defines.svh"

module radix_digit_converter_top #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rdc_pkg::RADIX_W-1:0] cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [rdc_pkg::WORD_W-1:0]  value,
    output logic                        empty,
    input  logic                        pop,
    output logic [rdc_pkg::CHAR_W-1:0]  digit_char,
    output logic [rdc_pkg::COUNT_W-1:0] digit_total,
    output logic                        last_digit
);
    import rdc_pkg::*;

    logic      item_valid;
    rdc_item_t item;
    logic      item_take;

    // front: config, classify, queue
    rdc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .value      (value),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // back: divide, store, emit
    rdc_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .pop         (pop),
        .empty       (empty),
        .digit_char  (digit_char),
        .digit_total (digit_total),
        .last_digit  (last_digit)
    );

    // result checks
    `RDC_ASSERT_IMPLY(a_char_legal, clk, rst_n, !empty, (digit_char >= 7'd48 && digit_char <= 7'd57) || (digit_char >= 7'd65 && digit_char <= 7'd90), "digit character out of range")
    `RDC_ASSERT_IMPLY(a_total_legal, clk, rst_n, !empty, digit_total != '0 && digit_total <= COUNT_W'(MAX_DIGITS), "digit total out of range")
    `RDC_ASSERT_IMPLY(a_single_last, clk, rst_n, !empty && digit_total == 7'd1, last_digit, "single digit not flagged last")
    `RDC_ASSERT_ALWAYS(a_take_valid, clk, rst_n, !item_take || item_valid, "item taken from empty queue")

endmodule
